>>> hw/rtl/fwm_pkg.sv
// ----------------------------------------------------------------------------
// Frame window multiplier package
// Shared widths, register indexes, window codes, cosine-sum coefficients
// and the command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fwm_pkg;

   // Field and register widths
   localparam int SAMPLE_W    = 24;
   localparam int TYPE_W      = 4;
   localparam int FRAME_LEN_W = 13;
   localparam int STEP_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int COEF_W      = 22;
   localparam int TERM_W      = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TYPE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP    = 2'd3;

   // Reset values of the registers
   localparam logic [TYPE_W-1:0]      RST_WINDOW_TYPE  = 4'd11;
   localparam logic [FRAME_LEN_W-1:0] RST_FRAME_LENGTH = 13'd1024;
   localparam logic [STEP_W-1:0]      RST_PHASE_STEP   = 32'd4198404;
   localparam logic [STEP_W-1:0]      RST_RAMP_STEP    = 32'd4194304;

   // Window codes
   localparam logic [TYPE_W-1:0] WT_BARTLETT = 4'd0;
   localparam logic [TYPE_W-1:0] WT_BLACKMAN = 4'd1;
   localparam logic [TYPE_W-1:0] WT_EXACT    = 4'd2;
   localparam logic [TYPE_W-1:0] WT_HARRIS   = 4'd3;
   localparam logic [TYPE_W-1:0] WT_BNUTTALL = 4'd4;
   localparam logic [TYPE_W-1:0] WT_FLATTOP  = 4'd5;
   localparam logic [TYPE_W-1:0] WT_HANN     = 4'd6;
   localparam logic [TYPE_W-1:0] WT_NUTTALL  = 4'd7;
   localparam logic [TYPE_W-1:0] WT_SINE     = 4'd8;
   localparam logic [TYPE_W-1:0] WT_TRI      = 4'd9;
   localparam logic [TYPE_W-1:0] WT_WELCH    = 4'd10;
   localparam logic [TYPE_W-1:0] WT_NONE     = 4'd11;

   localparam longint ONE_Q20 = 64'sd1048576;

   // Cosine-sum coefficients a0..a4 in Q20, rounded to nearest.
   // Rows follow the window codes; row 0 is unused.
   typedef logic signed [COEF_W-1:0] coef_row_type [5];
   typedef coef_row_type coef_tab_type [8];

   localparam coef_tab_type COEF_TAB = '{
      '{22'sd0, 22'sd0, 22'sd0, 22'sd0, 22'sd0},
      '{COEF_W'((64'sd84 * ONE_Q20 + 64'sd100) / 64'sd200),
        COEF_W'((64'sd1 * ONE_Q20 + 64'sd1) / 64'sd2),
        COEF_W'((64'sd16 * ONE_Q20 + 64'sd100) / 64'sd200),
        22'sd0, 22'sd0},
      '{COEF_W'((64'sd7938 * ONE_Q20 + 64'sd9304) / 64'sd18608),
        COEF_W'((64'sd9240 * ONE_Q20 + 64'sd9304) / 64'sd18608),
        COEF_W'((64'sd1430 * ONE_Q20 + 64'sd9304) / 64'sd18608),
        22'sd0, 22'sd0},
      '{COEF_W'((64'sd35875 * ONE_Q20 + 64'sd50000) / 64'sd100000),
        COEF_W'((64'sd48829 * ONE_Q20 + 64'sd50000) / 64'sd100000),
        COEF_W'((64'sd14128 * ONE_Q20 + 64'sd50000) / 64'sd100000),
        COEF_W'((64'sd1168 * ONE_Q20 + 64'sd50000) / 64'sd100000),
        22'sd0},
      '{COEF_W'((64'sd3635819 * ONE_Q20 + 64'sd5000000) / 64'sd10000000),
        COEF_W'((64'sd4891775 * ONE_Q20 + 64'sd5000000) / 64'sd10000000),
        COEF_W'((64'sd1365995 * ONE_Q20 + 64'sd5000000) / 64'sd10000000),
        COEF_W'((64'sd106411 * ONE_Q20 + 64'sd5000000) / 64'sd10000000),
        22'sd0},
      '{COEF_W'((64'sd1000 * ONE_Q20 + 64'sd500) / 64'sd1000),
        COEF_W'((64'sd1930 * ONE_Q20 + 64'sd500) / 64'sd1000),
        COEF_W'((64'sd1290 * ONE_Q20 + 64'sd500) / 64'sd1000),
        COEF_W'((64'sd388 * ONE_Q20 + 64'sd500) / 64'sd1000),
        COEF_W'((64'sd28 * ONE_Q20 + 64'sd500) / 64'sd1000)},
      '{COEF_W'((64'sd1 * ONE_Q20 + 64'sd1) / 64'sd2),
        COEF_W'((64'sd1 * ONE_Q20 + 64'sd1) / 64'sd2),
        22'sd0, 22'sd0, 22'sd0},
      '{COEF_W'((64'sd355768 * ONE_Q20 + 64'sd500000) / 64'sd1000000),
        COEF_W'((64'sd487396 * ONE_Q20 + 64'sd500000) / 64'sd1000000),
        COEF_W'((64'sd144232 * ONE_Q20 + 64'sd500000) / 64'sd1000000),
        COEF_W'((64'sd12604 * ONE_Q20 + 64'sd500000) / 64'sd1000000),
        22'sd0}
   };

   // Commands from the controller to the datapath, one bundle per cycle.
   typedef struct packed {
      logic              load;      // request accepted: capture sample and state
      logic              rom_rd;    // read the cosine table at the next harmonic
      logic              mul_term;  // multiply a coefficient by a table entry
      logic [TERM_W-1:0] term;      // which of a1..a4 the multiply uses
      logic              acc_en;    // add the previous product into the sum
      logic              acc_sub;   // subtract instead of add
      logic              weight;    // form the final window weight
      logic              mul_out;   // multiply the sample by the weight
      logic              out_load;  // load the result register
   } fwm_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/fwm_ctrl.sv
// ----------------------------------------------------------------------------
// Frame window multiplier controller
// Step sequencer that walks each request through the shared datapath and
// drives the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fwm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output fwm_pkg::fwm_cmd_type     cmd
);
   import fwm_pkg::*;

   localparam int SEQ_W = 4;

   localparam logic [SEQ_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [SEQ_W-1:0] ST_TERM1  = 4'd1;
   localparam logic [SEQ_W-1:0] ST_TERM2  = 4'd2;
   localparam logic [SEQ_W-1:0] ST_TERM3  = 4'd3;
   localparam logic [SEQ_W-1:0] ST_TERM4  = 4'd4;
   localparam logic [SEQ_W-1:0] ST_ACC4   = 4'd5;
   localparam logic [SEQ_W-1:0] ST_WEIGHT = 4'd6;
   localparam logic [SEQ_W-1:0] ST_MULOUT = 4'd7;
   localparam logic [SEQ_W-1:0] ST_RESULT = 4'd8;

   logic [SEQ_W-1:0] state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             accept;
   fwm_cmd_type      cmd_dec;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_RESULT) && out_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd_dec = '0;
      unique case (state_ff)
         ST_TERM1: begin
            cmd_dec.rom_rd   = 1'b1;
            cmd_dec.mul_term = 1'b1;
            cmd_dec.term     = 2'd0;
         end
         ST_TERM2: begin
            cmd_dec.rom_rd   = 1'b1;
            cmd_dec.mul_term = 1'b1;
            cmd_dec.term     = 2'd1;
            cmd_dec.acc_en   = 1'b1;
            cmd_dec.acc_sub  = 1'b1;
         end
         ST_TERM3: begin
            cmd_dec.rom_rd   = 1'b1;
            cmd_dec.mul_term = 1'b1;
            cmd_dec.term     = 2'd2;
            cmd_dec.acc_en   = 1'b1;
         end
         ST_TERM4: begin
            cmd_dec.mul_term = 1'b1;
            cmd_dec.term     = 2'd3;
            cmd_dec.acc_en   = 1'b1;
            cmd_dec.acc_sub  = 1'b1;
         end
         ST_ACC4: begin
            cmd_dec.acc_en = 1'b1;
         end
         ST_WEIGHT: begin
            cmd_dec.weight = 1'b1;
         end
         ST_MULOUT: begin
            cmd_dec.mul_out = 1'b1;
         end
         ST_RESULT: begin
            cmd_dec.out_load = out_free;
         end
         default: begin
            cmd_dec = '0;
         end
      endcase
      cmd_dec.load = accept;
   end

   assign cmd = cmd_dec;

   always_comb begin
      if (accept) begin
         state_in = ST_TERM1;
      end else if (state_ff == ST_RESULT) begin
         state_in = out_free ? ST_IDLE : ST_RESULT;
      end else if (state_ff == ST_IDLE) begin
         state_in = ST_IDLE;
      end else begin
         state_in = SEQ_W'(state_ff + 4'd1);
      end
   end

   always_comb begin
      if (cmd_dec.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A request is only taken when idle or on the cycle the result is stored.
   a_accept_slot: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((state_ff == ST_IDLE) || (state_ff == ST_RESULT)))
      else $error("request accepted in the middle of a computation");

   // The result register is never overwritten while a result waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_dec.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");

   // An accepted request always starts the sequence from the first term.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_TERM1))
      else $error("sequence did not start after accept");

   // A finished computation holds while the receiver stalls a pending result.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESULT) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_RESULT))
      else $error("result step left while blocked");

endmodule

`default_nettype wire

>>> hw/rtl/fwm_datapath.sv
// ----------------------------------------------------------------------------
// Frame window multiplier datapath
// Configuration registers, frame counter and accumulators, cosine table,
// shared multiplier, weight formation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwm_datapath #(
   parameter int MAX_FRAME       = 4096,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [fwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fwm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic signed [fwm_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire fwm_pkg::fwm_cmd_type                cmd,
   output logic signed [fwm_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   output logic                                     rsp_frame_end
);
   import fwm_pkg::*;

   localparam int IDX_W   = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int MF_W    = $clog2(MAX_FRAME + 1);
   localparam int LEN_W   = (MF_W > FRAME_LEN_W) ? MF_W : FRAME_LEN_W;
   localparam int ADDR_W  = $clog2(COS_TABLE_DEPTH);
   localparam int DEPTH_W = $clog2(COS_TABLE_DEPTH + 1);
   localparam int SCL_W   = STEP_W + DEPTH_W;
   localparam int COS_W   = 22;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 46;
   localparam int DIST_W  = 34;
   localparam int T_W     = 36;

   localparam logic signed [T_W-1:0]    TWO32    = 36'sd4294967296;
   localparam logic signed [T_W-1:0]    RND12    = 36'sd2048;
   localparam logic signed [PROD_W-1:0] TWO62    = PROD_W'(64'sd4611686018427387904);
   localparam logic signed [PROD_W-1:0] RND42    = PROD_W'(64'sd2199023255552);
   localparam logic signed [PROD_W-1:0] RND20P   = PROD_W'(64'sd524288);
   localparam logic signed [ACC_W-1:0]  RND20A   = ACC_W'(64'sd524288);
   localparam logic signed [ACC_W-1:0]  SAT_HI   = ACC_W'(64'sd8388607);
   localparam logic signed [ACC_W-1:0]  SAT_LO   = -ACC_W'(64'sd8388608);

   localparam logic [1:0] CLS_COS   = 2'd0;
   localparam logic [1:0] CLS_RAMP  = 2'd1;
   localparam logic [1:0] CLS_WELCH = 2'd2;
   localparam logic [1:0] CLS_PASS  = 2'd3;

   // ------------------------------------------------------------------------
   // Cosine table, built at elaboration from a Taylor series on the quarter
   // wave and read through a registered port.
   // ------------------------------------------------------------------------
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint DIVS [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};

   typedef logic signed [COS_W-1:0] cos_rom_type [COS_TABLE_DEPTH];

   function automatic longint quarter_cos(longint r);
      longint x;
      longint x2;
      longint t;
      longint p;
      x = (r * PI_Q30) >>> 31;
      x2 = (x * x) >>> 30;
      t = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
         p = x2 * t;
         p = (p >= 0) ? (p >>> 30) : -((-p) >>> 30);
         t = ONE_Q30 - p / DIVS[i];
      end
      return (t < 0) ? 64'sd0 : t;
   endfunction

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      longint p;
      longint q;
      longint r;
      longint c;
      for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
         p = (longint'(i) <<< 32) / COS_TABLE_DEPTH;
         q = (p >>> 30) & 64'sd3;
         r = p & 64'sh3FFFFFFF;
         if (q == 0 || q == 2) begin
            c = quarter_cos(r);
         end else begin
            c = quarter_cos(ONE_Q30 - r);
         end
         c = (c + 64'sd512) >>> 10;
         rom[i] = (q == 1 || q == 2) ? COS_W'(-c) : COS_W'(c);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

   // ------------------------------------------------------------------------
   // Signals
   // ------------------------------------------------------------------------
   logic [TYPE_W-1:0]      type_ff, type_in;
   logic [FRAME_LEN_W-1:0] flen_ff, flen_in;
   logic [STEP_W-1:0]      pstep_ff, pstep_in;
   logic [STEP_W-1:0]      rstep_ff, rstep_in;

   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [STEP_W-1:0]      phase_ff, phase_in;
   logic [STEP_W-1:0]      ramp_ff, ramp_in;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic [STEP_W-1:0]          harm_ff, harm_in;
   logic [STEP_W-1:0]          base_ff, base_in;
   logic [DIST_W-1:0]          dist_ff, dist_in;
   logic signed [COS_W-1:0]    cosq_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] w_ff, w_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_last_ff, out_last_in;

   logic [1:0]             wclass;
   logic [LEN_W-1:0]       len_ext;
   logic [LEN_W-1:0]       len_clamp;
   logic [LEN_W-1:0]       len_m1;
   logic                   frame_last;
   logic signed [T_W-1:0]  bart_t;
   logic signed [T_W-1:0]  tri_t;
   logic [T_W-1:0]         bart_abs;
   logic [T_W-1:0]         tri_abs;
   logic [STEP_W-1:0]      rd_phase;
   logic [SCL_W-1:0]       rd_scaled;
   logic [ADDR_W-1:0]      rom_addr;
   logic [2:0]             coef_row;
   logic [2:0]             coef_col;
   logic signed [COEF_W-1:0] coef_sel;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [T_W-1:0]    ramp_v;
   logic signed [PROD_W-1:0] welch_v;
   logic signed [PROD_W-1:0] out_rnd;
   logic signed [ACC_W-1:0]  out_y;
   logic signed [SAMPLE_W-1:0] out_sat;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   always_comb begin
      type_in  = type_ff;
      flen_in  = flen_ff;
      pstep_in = pstep_ff;
      rstep_in = rstep_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_TYPE:  type_in  = csr_wdata[TYPE_W-1:0];
            CSR_FRAME_LENGTH: flen_in  = csr_wdata[FRAME_LEN_W-1:0];
            CSR_PHASE_STEP:   pstep_in = csr_wdata[STEP_W-1:0];
            CSR_RAMP_STEP:    rstep_in = csr_wdata[STEP_W-1:0];
            default:          type_in  = type_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff  <= RST_WINDOW_TYPE;
         flen_ff  <= RST_FRAME_LENGTH;
         pstep_ff <= RST_PHASE_STEP;
         rstep_ff <= RST_RAMP_STEP;
      end else begin
         type_ff  <= type_in;
         flen_ff  <= flen_in;
         pstep_ff <= pstep_in;
         rstep_ff <= rstep_in;
      end
   end

   // Window family of the selected code
   always_comb begin
      if (type_ff == WT_BARTLETT || type_ff == WT_TRI) begin
         wclass = CLS_RAMP;
      end else if (type_ff == WT_WELCH) begin
         wclass = CLS_WELCH;
      end else if (type_ff >= WT_BLACKMAN && type_ff <= WT_NUTTALL) begin
         wclass = CLS_COS;
      end else begin
         wclass = CLS_PASS;
      end
   end

   // ------------------------------------------------------------------------
   // Frame position and accumulators
   // ------------------------------------------------------------------------
   always_comb begin
      len_ext = LEN_W'(flen_ff);
      if (len_ext < LEN_W'(2)) begin
         len_clamp = LEN_W'(2);
      end else if (len_ext > LEN_W'(MAX_FRAME)) begin
         len_clamp = LEN_W'(MAX_FRAME);
      end else begin
         len_clamp = len_ext;
      end
      len_m1     = len_clamp - LEN_W'(1);
      frame_last = LEN_W'(idx_ff) >= len_m1;
   end

   always_comb begin
      idx_in   = idx_ff;
      phase_in = phase_ff;
      ramp_in  = ramp_ff;
      if (cmd.load) begin
         if (frame_last) begin
            idx_in   = '0;
            phase_in = '0;
            ramp_in  = '0;
         end else begin
            idx_in   = IDX_W'(idx_ff + 1'b1);
            phase_in = phase_ff + pstep_ff;
            ramp_in  = ramp_ff + rstep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         phase_ff <= '0;
         ramp_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         ramp_ff  <= ramp_in;
      end
   end

   // ------------------------------------------------------------------------
   // Request capture: sample, harmonic phases and the ramp distance
   // ------------------------------------------------------------------------
   assign bart_t   = $signed({3'b000, phase_ff, 1'b0}) - TWO32;
   assign tri_t    = $signed({3'b000, ramp_ff, 1'b0}) - TWO32 + $signed({4'b0000, rstep_ff});
   assign bart_abs = bart_t[T_W-1] ? T_W'(-bart_t) : T_W'(bart_t);
   assign tri_abs  = tri_t[T_W-1] ? T_W'(-tri_t) : T_W'(tri_t);

   always_comb begin
      sample_in = sample_ff;
      last_in   = last_ff;
      base_in   = base_ff;
      harm_in   = harm_ff;
      dist_in   = dist_ff;
      if (cmd.load) begin
         sample_in = req_sample_in;
         last_in   = frame_last;
         base_in   = phase_ff;
         harm_in   = {phase_ff[STEP_W-2:0], 1'b0};
         dist_in   = (type_ff == WT_TRI) ? tri_abs[DIST_W-1:0] : bart_abs[DIST_W-1:0];
      end else if (cmd.rom_rd) begin
         harm_in = harm_ff + base_ff;
      end
   end

   // Table address: floor(phase * depth / 2^32)
   assign rd_phase  = cmd.load ? phase_ff : harm_ff;
   assign rd_scaled = SCL_W'(rd_phase) * SCL_W'(COS_TABLE_DEPTH);
   assign rom_addr  = rd_scaled[STEP_W+ADDR_W-1:STEP_W];

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.rom_rd) begin
         cosq_ff <= COS_ROM[rom_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Shared multiplier
   // ------------------------------------------------------------------------
   assign coef_row = type_ff[2:0];
   assign coef_col = 3'(cmd.term) + 3'd1;
   assign coef_sel = COEF_TAB[coef_row][coef_col];

   always_comb begin
      if (cmd.mul_out) begin
         mul_a = MUL_W'(sample_ff);
         mul_b = MUL_W'(w_ff);
      end else if (wclass == CLS_WELCH) begin
         mul_a = $signed({1'b0, dist_ff[STEP_W:1]});
         mul_b = $signed({1'b0, dist_ff[STEP_W:1]});
      end else begin
         mul_a = MUL_W'(coef_sel);
         mul_b = MUL_W'(cosq_ff);
      end
      prod_in = (cmd.mul_term || cmd.mul_out) ? (mul_a * mul_b) : prod_ff;
   end

   // ------------------------------------------------------------------------
   // Cosine sum, weight and result
   // ------------------------------------------------------------------------
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = ACC_W'(COEF_TAB[coef_row][0]) <<< 20;
      end else if (cmd.acc_en) begin
         if (cmd.acc_sub) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign acc_rnd = acc_ff + RND20A;
   assign ramp_v  = TWO32 - $signed({2'b00, dist_ff}) + RND12;
   assign welch_v = TWO62 - prod_ff + RND42;

   always_comb begin
      w_in = w_ff;
      if (cmd.weight) begin
         unique case (wclass)
            CLS_COS:   w_in = acc_rnd[20+SAMPLE_W-1:20];
            CLS_RAMP:  w_in = ramp_v[12+SAMPLE_W-1:12];
            CLS_WELCH: w_in = welch_v[42+SAMPLE_W-1:42];
            CLS_PASS:  w_in = w_ff;
            default:   w_in = w_ff;
         endcase
      end
   end

   assign out_rnd = prod_ff + RND20P;
   assign out_y   = $signed(out_rnd[20+ACC_W-1:20]);

   always_comb begin
      if (out_y > SAT_HI) begin
         out_sat = SAT_HI[SAMPLE_W-1:0];
      end else if (out_y < SAT_LO) begin
         out_sat = SAT_LO[SAMPLE_W-1:0];
      end else begin
         out_sat = out_y[SAMPLE_W-1:0];
      end
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_load) begin
         out_sample_in = (wclass == CLS_PASS) ? sample_ff : out_sat;
         out_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      base_ff       <= base_in;
      harm_ff       <= harm_in;
      dist_ff       <= dist_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      w_ff          <= w_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_sample_out = out_sample_ff;
   assign rsp_frame_end  = out_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/frame_window_multiplier_core.sv
// ----------------------------------------------------------------------------
// Frame window multiplier core
// Multiplies a stream of Q1.23 audio samples by a frame window weight
// (ramp, Welch, cosine-sum or none) chosen through the register port.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_stall with one sample each; every
//   request yields exactly one result on rsp_valid / rsp_stall carrying the
//   windowed, saturated sample and a flag marking the last sample of a frame.
//   A request or result moves at a clock edge where valid is high and stall
//   is low. Registers are written through csr_write_en, csr_index and
//   csr_wdata while no request is in flight.
//   The result is registered in the last step of the sequence, once the
//   output register is free, and rsp_valid is high from the next cycle.
//   The core takes no new request before the last one is done. The
//   cosine-sum windows need four table reads and four products through one
//   shared multiplier, then the product of weight and sample, and the step
//   sequencer runs all windows through the same eight steps.
//   While a request is being computed req_stall stays high. The next
//   request is taken on the same edge that stores a result, so a result
//   waiting in the output register costs nothing by itself; when a new
//   result is ready while the previous one is still stalled, the core
//   keeps req_stall high until the receiver takes the old one.
//   Reset (synchronous, active high) clears the sequencer, the result valid,
//   the frame position and both accumulators, and restores the register
//   defaults: no window, 1024 samples per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_window_multiplier_core #(
   parameter int MAX_FRAME       = 4096,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Register port
   input  wire logic                                csr_write_en,
   input  wire logic [fwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fwm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [fwm_pkg::SAMPLE_W-1:0] req_sample_in,
   // Result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [fwm_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   output logic                                     rsp_frame_end
);
   import fwm_pkg::*;

   // Per-cycle command bundle from the sequencer to the datapath.
   fwm_cmd_type cmd;

   // The sequencer owns both handshakes and decides when each step runs.
   fwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the registers, frame state, table and multiplier.
   fwm_datapath #(
      .MAX_FRAME       (MAX_FRAME),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .cmd            (cmd),
      .rsp_sample_out (rsp_sample_out),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire
